@@ rtl/ftdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftdt_pkg: shared types and constants for float_to_decimal_text
// Float constants, sequencer states, character codes, the multiplier request type and helpers.
// ----------------------------------------------------------------------------
package ftdt_pkg;

    localparam logic [31:0] F_1000  = 32'h447A0000;
    localparam logic [31:0] F_0P001 = 32'h3A83126F;
    localparam logic [31:0] F_0P1   = 32'h3DCCCCCD;
    localparam logic [31:0] F_10    = 32'h41200000;
    localparam logic [31:0] F_1E6   = 32'h49742400;
    localparam logic [31:0] F_1     = 32'h3F800000;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_CAP_N = 8'h4E;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_F     = 8'h66;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BIG3,
        ST_BIG1,
        ST_SML3,
        ST_SML1,
        ST_SCALE,
        ST_ROUND,
        ST_SPLIT,
        ST_STRIP,
        ST_DIGITS,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    // Positive normal single-precision compare (magnitudes only)
    function automatic logic f_ge(input logic [31:0] x, input logic [31:0] y);
        return x[30:0] >= y[30:0];
    endfunction

    // Divide by ten with a reciprocal multiply; exact below 2^26
    function automatic logic [23:0] f_div10(input logic [23:0] x);
        logic [47:0] p;
        p = 48'(x) * 48'd13421773;
        return {3'b0, p[47:27]};
    endfunction

    // Leading decimal digit of a seven-digit significand
    function automatic logic [3:0] f_hi_digit(input logic [23:0] x);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (x >= 24'(k * 1000000))
                d = 4'(k);
        end
        return d;
    endfunction

    // Tens digit of an exponent magnitude
    function automatic logic [3:0] f_tens(input logic [6:0] x);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 7; k++)
        begin
            if (x >= 7'(k * 10))
                d = 4'(k);
        end
        return d;
    endfunction

endpackage

@@ rtl/float_to_decimal_text.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_decimal_text: float32 to decimal ASCII text
// Converts one float per beat into its scientific-style text, a char a beat.
// ----------------------------------------------------------------------------
// Zero, NaN and infinity reach the output the cycle after the beat; other
// values pass through the shared multiplier in the scaling loops and the
// 1e6 scale, then round, split, strip and digit split before the first char.
// One value at a time: a new float is taken only after its last character,
// and characters go out one beat per cycle while m_tready is high.
// Reset: rst_n clears the sequencer and output valid asynchronously.
module float_to_decimal_text
    import ftdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_code
    output logic        m_tlast    // last_char
);

    state_t state_reg, state_next;
    logic [31:0] v_reg, v_next;
    logic signed [6:0] e_reg, e_next;
    logic        neg_reg, neg_next;
    logic        wait_reg, wait_next;
    logic [23:0] sig_reg, sig_next;
    logic [19:0] frac_reg, frac_next;
    logic [2:0]  fd_reg, fd_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [3:0]  dig_reg [0:5];
    logic [3:0]  dig_next [0:5];
    logic [7:0]  buf_reg [0:12];
    logic [7:0]  buf_next [0:12];
    logic [3:0]  len_reg, len_next;
    logic [3:0]  pos_reg, pos_next;

    mul_req_t    mreq;
    logic [31:0] mprod;
    logic        mdone;

    ftdt_fmul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .prod(mprod), .done(mdone));

    logic [31:0] t;
    logic [24:0] q;
    logic [6:0]  ae;
    logic [3:0]  at;
    logic [3:0]  n;
    logic [23:0] fq;
    logic [3:0]  fr;
    logic [3:0]  hi;

    assign fq = f_div10({4'd0, frac_reg});
    assign fr = 4'({4'd0, frac_reg} - (fq << 3) - (fq << 1));
    assign hi = f_hi_digit(sig_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    if ((s_tdata[30:23] == 8'hFF) || (s_tdata[30:0] == 31'd0))
                        state_next = ST_EMIT;
                    else if (f_ge(s_tdata, F_10))
                        state_next = ST_BIG3;
                    else if (!f_ge(s_tdata, F_1))
                        state_next = ST_SML3;
                    else
                        state_next = ST_SCALE;
                end
            ST_BIG3:
                if (!wait_reg && !f_ge(v_reg, F_1000))
                    state_next = ST_BIG1;
            ST_BIG1:
                if (!wait_reg && !f_ge(v_reg, F_10))
                    state_next = ST_SCALE;
            ST_SML3:
                if (!wait_reg && f_ge(v_reg, F_0P001))
                    state_next = ST_SML1;
            ST_SML1:
                if (!wait_reg && f_ge(v_reg, F_1))
                    state_next = ST_SCALE;
            ST_SCALE:
                if (wait_reg && mdone)
                    state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_SPLIT;
            ST_SPLIT:  state_next = ST_STRIP;
            ST_STRIP:
                if (cnt_reg != 3'd0 && (fd_reg == 3'd0 || fr != 4'd0))
                    state_next = ST_DIGITS;
            ST_DIGITS:
                if (cnt_reg == 3'd5)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (m_tready && pos_reg == len_reg - 4'd1)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        v_next = v_reg;
        e_next = e_reg;
        neg_next = neg_reg;
        wait_next = wait_reg;
        sig_next = sig_reg;
        frac_next = frac_reg;
        fd_next = fd_reg;
        cnt_next = cnt_reg;
        dig_next = dig_reg;
        buf_next = buf_reg;
        len_next = len_reg;
        pos_next = pos_reg;
        mreq = '0;
        t = 32'd0;
        q = 25'd0;
        ae = 7'd0;
        at = 4'd0;
        n = 4'd0;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    v_next = {1'b0, s_tdata[30:0]};
                    neg_next = s_tdata[31];
                    e_next = 7'sd0;
                    wait_next = 1'b0;
                    pos_next = 4'd0;
                    if (s_tdata[30:23] == 8'hFF && s_tdata[22:0] != 23'd0)
                    begin
                        buf_next[0] = CH_CAP_N;
                        buf_next[1] = CH_A;
                        buf_next[2] = CH_CAP_N;
                        len_next = 4'd3;
                    end
                    else if (s_tdata[30:0] == 31'd0)
                    begin
                        buf_next[0] = CH_0;
                        len_next = 4'd1;
                    end
                    else if (s_tdata[30:23] == 8'hFF)
                    begin
                        n = s_tdata[31] ? 4'd1 : 4'd0;
                        buf_next[0] = CH_MINUS;
                        buf_next[n] = CH_I;
                        buf_next[n + 4'd1] = CH_N;
                        buf_next[n + 4'd2] = CH_F;
                        len_next = n + 4'd3;
                    end
                end
            ST_BIG3, ST_BIG1, ST_SML3, ST_SML1:
            begin
                if (wait_reg)
                begin
                    if (mdone)
                    begin
                        v_next = mprod;
                        wait_next = 1'b0;
                    end
                end
                else if (state_next == state_reg)
                begin
                    mreq.start = 1'b1;
                    mreq.a = v_reg;
                    wait_next = 1'b1;
                    case (state_reg)
                        ST_BIG3: begin mreq.b = F_0P001; e_next = e_reg + 7'sd3; end
                        ST_BIG1: begin mreq.b = F_0P1; e_next = e_reg + 7'sd1; end
                        ST_SML3: begin mreq.b = F_1000; e_next = e_reg - 7'sd3; end
                        default: begin mreq.b = F_10; e_next = e_reg - 7'sd1; end
                    endcase
                end
            end
            ST_SCALE:
                if (!wait_reg)
                begin
                    mreq.start = 1'b1;
                    mreq.a = v_reg;
                    mreq.b = F_1E6;
                    wait_next = 1'b1;
                end
                else if (mdone)
                begin
                    v_next = mprod;
                    wait_next = 1'b0;
                end
            ST_ROUND:
            begin
                // v in [1e6,1e7): integer part plus 0.5 rounded in float
                t = v_reg;
                q = {1'b1, t[22:0], 1'b0} >> (5'd23 - 5'(t[30:23] - 8'd127));
                // q holds 2*v truncated; float add 0.5 then truncate
                if (t[30:23] - 8'd127 >= 8'd23)
                    sig_next = 24'({1'b1, t[22:0]} << (t[30:23] - 8'd150));
                else
                    sig_next = 24'((q + 25'd1) >> 1);
                // Odd integer plus one half ties up to the even neighbor
                if (t[30:23] == 8'd150 && t[0])
                    sig_next = 24'({1'b1, t[22:0]}) + 24'd1;
            end
            ST_SPLIT:
            begin
                if (sig_reg >= 24'd10000000)
                begin
                    sig_next = f_div10(sig_reg);
                    e_next = e_reg + 7'sd1;
                end
                fd_next = 3'd6;
                cnt_next = 3'd0;
            end
            ST_STRIP:
            begin
                if (cnt_reg == 3'd0)
                begin
                    frac_next = 20'(sig_reg - 24'(hi) * 24'd1000000);
                    cnt_next = 3'd1;
                end
                else if (fd_reg != 3'd0 && fr == 4'd0)
                begin
                    frac_next = 20'(fq);
                    fd_next = fd_reg - 3'd1;
                end
                if (state_next == ST_DIGITS)
                    cnt_next = 3'd0;
            end
            ST_DIGITS:
            begin
                dig_next[3'd5 - cnt_reg] = fr;
                frac_next = 20'(fq);
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    n = 4'd0;
                    if (neg_reg)
                    begin
                        buf_next[0] = CH_MINUS;
                        n = 4'd1;
                    end
                    buf_next[n] = CH_0 + 8'(hi);
                    n = n + 4'd1;
                    if (fd_reg != 3'd0)
                    begin
                        buf_next[n] = CH_DOT;
                        n = n + 4'd1;
                        for (int i = 0; i < 6; i++)
                        begin
                            if (3'(i) < fd_reg)
                                buf_next[n + 4'(i)] =
                                    CH_0 + 8'(dig_next[3'd6 - fd_reg + 3'(i)]);
                        end
                        n = n + 4'(fd_reg);
                    end
                    if (e_next != 7'sd0)
                    begin
                        buf_next[n] = CH_E;
                        n = n + 4'd1;
                        ae = e_next[6] ? 7'(-e_next) : 7'(e_next);
                        at = f_tens(ae);
                        if (e_next[6])
                        begin
                            buf_next[n] = CH_MINUS;
                            n = n + 4'd1;
                        end
                        if (ae >= 7'd10)
                        begin
                            buf_next[n] = CH_0 + 8'(at);
                            n = n + 4'd1;
                        end
                        buf_next[n] = CH_0 + 8'(ae - {3'd0, at} * 7'd10);
                        n = n + 4'd1;
                    end
                    len_next = n;
                end
            end
            ST_EMIT:
                if (m_tready)
                    pos_next = pos_reg + 4'd1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        e_reg <= e_next;
        neg_reg <= neg_next;
        sig_reg <= sig_next;
        frac_reg <= frac_next;
        fd_reg <= fd_next;
        cnt_reg <= cnt_next;
        dig_reg <= dig_next;
        buf_reg <= buf_next;
        len_reg <= len_next;
        pos_reg <= pos_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = buf_reg[pos_reg];
    assign m_tlast  = (pos_reg == len_reg - 4'd1);

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("input and output both open");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready) else $error("no return to idle");
    a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (len_reg != 4'd0 && pos_reg < len_reg)) else $error("bad position");
`endif

endmodule

@@ rtl/ftdt_fmul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftdt_fmul: shared single-precision multiplier
// Positive operands, b always normal; round to nearest even; registered product, done a registered req.start.
// ----------------------------------------------------------------------------
module ftdt_fmul
    import ftdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mul_req_t    req,
    output logic [31:0] prod,
    output logic        done
);

    logic [47:0] mp_reg;
    logic signed [10:0] ex_reg;
    logic        v1_reg;

    logic [23:0] ma, mb;
    logic [7:0]  ea_adj;
    logic [4:0]  lz;
    logic [23:0] man_n;

    // Normalize a subnormal a operand before multiplying
    always_comb
    begin
        lz = 5'd0;
        for (int i = 22; i >= 0; i--)
        begin
            if (req.a[i] && lz == 5'd0 && req.a[30:23] == 8'd0)
                lz = 5'(23 - i);
        end
    end

    always_comb
    begin
        man_n = {1'b0, req.a[22:0]} << lz;
        if (req.a[30:23] == 8'd0)
        begin
            ma = man_n;
            ea_adj = 8'd1;
        end
        else
        begin
            ma = {1'b1, req.a[22:0]};
            ea_adj = req.a[30:23];
        end
        mb = {1'b1, req.b[22:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= req.start;
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mp_reg <= ma * mb;
            ex_reg <= 11'(signed'({3'b0, ea_adj})) - 11'(signed'({6'b0, lz}))
                    + 11'(signed'({3'b0, req.b[30:23]})) - 11'sd127;
        end
    end

    logic [47:0] mn;
    logic signed [10:0] en;
    logic [23:0] keep;
    logic        g, s;
    logic [24:0] rnd;
    logic [5:0]  sh;
    logic [71:0] wide;

    always_comb
    begin
        if (mp_reg[47])
        begin
            mn = mp_reg;
            en = ex_reg + 11'sd1;
        end
        else
        begin
            mn = {mp_reg[46:0], 1'b0};
            en = ex_reg;
        end
        // Denormalize result when exponent is at or below zero
        if (en <= 11'sd0)
        begin
            sh = (en < -11'sd30) ? 6'd31 : 6'(11'sd1 - en);
            wide = {mn, 24'd0} >> sh;
        end
        else
        begin
            sh = 6'd0;
            wide = {mn, 24'd0};
        end
        keep = wide[71:48];
        g = wide[47];
        s = |wide[46:0];
        rnd = {1'b0, keep} + 25'(g & (s | keep[0]));
        if (en <= 11'sd0)
            prod = {1'b0, 8'(rnd[23]), rnd[22:0]};
        else if (rnd[24])
            prod = {1'b0, 8'(en + 11'sd1), rnd[23:1]};
        else
            prod = {1'b0, 8'(en), rnd[22:0]};
    end

    assign done = v1_reg;

endmodule

@@ tb/float_to_decimal_text_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_decimal_text_test: self-checking bench for float_to_decimal_text
// Sends raw single-precision patterns as bursts of beats and predicts each
// character with a bit-exact float32 model built on integer arithmetic:
// round-to-nearest-even multiplies, one add and a truncation. Every output
// character beat and its last mark are checked in order. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module float_to_decimal_text_test
    import ftdt_pkg::*;
;

    localparam int          STALL_LIMIT = 3000;
    localparam logic [31:0] F_HALF      = 32'h3F000000;

    class text_board;
        logic [8:0] chars_q[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        // Split a float into integer significand and binary exponent.
        function void unpack(input logic [31:0] f, output longint unsigned p,
                             output int e);
            if (f[30:23] == 8'd0)
            begin
                p = f[22:0];
                e = -149;
            end
            else
            begin
                p = {1'b1, f[22:0]};
                e = int'(f[30:23]) - 150;
            end
        endfunction

        // Round p * 2^e to float32, nearest even.
        function logic [31:0] round_pack(input longint unsigned p, input int e);
            int              msb;
            int              be;
            int              sh;
            longint unsigned q;
            longint unsigned rem;
            longint unsigned half;
            msb = 63;
            while (msb > 0 && p[msb] == 1'b0)
                msb--;
            be = msb + e + 127;
            sh = msb - 23;
            if (be < 1)
                sh = sh + (1 - be);
            if (sh > 62)
                sh = 62;
            if (sh > 0)
            begin
                q    = p >> sh;
                rem  = p & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0]))
                    q = q + 1;
            end
            else
                q = p << (-sh);
            if (be < 1)
                return q[31:0];
            return 32'((longint'(be - 1) << 23) + q);
        endfunction

        function logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
            longint unsigned pa;
            longint unsigned pb;
            int              ea;
            int              eb;
            unpack(a, pa, ea);
            unpack(b, pb, eb);
            return round_pack(pa * pb, ea + eb);
        endfunction

        function logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
            longint unsigned pa;
            longint unsigned pb;
            int              ea;
            int              eb;
            int              em;
            unpack(a, pa, ea);
            unpack(b, pb, eb);
            em = (ea < eb) ? ea : eb;
            return round_pack((pa << (ea - em)) + (pb << (eb - em)), em);
        endfunction

        function int unsigned trunc_u(input logic [31:0] f);
            longint unsigned p;
            int              e;
            unpack(f, p, e);
            if (e >= 0)
                return int'(p << e);
            return int'(p >> (-e));
        endfunction

        // Note one accepted float and queue its expected text.
        function void note_value(input logic [31:0] bits);
            logic [7:0]  txt[$];
            logic [31:0] v;
            int          e10;
            int unsigned sig;
            int unsigned frac;
            int unsigned dv;
            int unsigned ae;
            int          fdig;
            v = {1'b0, bits[30:0]};
            e10 = 0;
            fdig = 6;
            if (bits[30:23] == 8'hFF && bits[22:0] != 0)
                txt = '{"N", "a", "N"};
            else if (v == 0)
                txt.push_back(CH_0);
            else if (bits[30:23] == 8'hFF)
            begin
                if (bits[31])
                    txt.push_back(CH_MINUS);
                txt.push_back("i");
                txt.push_back("n");
                txt.push_back("f");
            end
            else
            begin
                if (v >= F_10)
                begin
                    while (v >= F_1000)
                    begin
                        v = fmul(v, F_0P001);
                        e10 += 3;
                    end
                    while (v >= F_10)
                    begin
                        v = fmul(v, F_0P1);
                        e10 += 1;
                    end
                end
                else if (v < F_1)
                begin
                    while (v < F_0P001)
                    begin
                        v = fmul(v, F_1000);
                        e10 -= 3;
                    end
                    while (v < F_1)
                    begin
                        v = fmul(v, F_10);
                        e10 -= 1;
                    end
                end
                sig = trunc_u(fadd(fmul(v, F_1E6), F_HALF));
                if (sig >= 10000000)
                begin
                    sig = sig / 10;
                    e10++;
                end
                frac = sig % 1000000;
                while (fdig > 0 && frac % 10 == 0)
                begin
                    frac = frac / 10;
                    fdig--;
                end
                if (bits[31])
                    txt.push_back(CH_MINUS);
                txt.push_back(CH_0 + 8'((sig / 1000000) % 10));
                if (fdig > 0)
                begin
                    txt.push_back(CH_DOT);
                    dv = 1;
                    for (int i = 1; i < fdig; i++)
                        dv = dv * 10;
                    for (int i = 0; i < fdig; i++)
                    begin
                        txt.push_back(CH_0 + 8'((frac / dv) % 10));
                        dv = dv / 10;
                    end
                end
                if (e10 != 0)
                begin
                    txt.push_back(CH_E);
                    if (e10 < 0)
                        txt.push_back(CH_MINUS);
                    ae = (e10 < 0) ? -e10 : e10;
                    if (ae >= 10)
                        txt.push_back(CH_0 + 8'((ae / 10) % 10));
                    txt.push_back(CH_0 + 8'(ae % 10));
                end
            end
            foreach (txt[i])
                chars_q.push_back({i == txt.size() - 1, txt[i]});
        endfunction

        function void check_char(input logic [7:0] code, input logic last);
            logic [8:0] exp_c;
            if (chars_q.size() == 0)
            begin
                $display("%0t: unexpected char beat %h last %b", $time, code, last);
                errors++;
                return;
            end
            exp_c = chars_q.pop_front();
            if (exp_c[7:0] !== code)
            begin
                $display("%0t: char expected %h actual %h", $time, exp_c[7:0], code);
                errors++;
            end
            if (exp_c[8] !== last)
            begin
                $display("%0t: last expected %b actual %b", $time, exp_c[8], last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value_bits
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] char_code
    logic        m_tlast;   // last_char

    text_board   board;
    int          idle_cycles;
    int unsigned ready_cnt;
    int unsigned ready_mode;

    float_to_decimal_text DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver stall pattern: pick a new style at random when ready_cnt[5:0] is 63.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_cnt  <= 0;
            ready_mode <= 0;
        end
        else
        begin
            ready_cnt <= ready_cnt + 1;
            if (ready_cnt[5:0] == 6'd63)
                ready_mode <= $urandom_range(3);
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(1));
                2: m_tready <= (ready_cnt[1:0] == 2'd0);
                default: m_tready <= ($urandom_range(7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_value(s_tdata);
            if (m_tvalid && m_tready)
                board.check_char(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_value(input logic [31:0] bits);
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic pause_sender();
        int gap;
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    function automatic logic [31:0] random_value();
        int unsigned kind;
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2: return $urandom();
            3: return {1'($urandom), 8'($urandom_range(110, 150)), 23'($urandom)};
            4: return {1'($urandom), 8'($urandom_range(0, 3)), 23'($urandom)};
            5: return {1'($urandom), 8'hFF, 23'($urandom_range(1))};
            6: return {1'($urandom), 8'($urandom_range(250, 254)), 23'($urandom)};
            7: return {1'($urandom), 8'($urandom_range(126, 130)), 23'h7FFFFF};
            default: return {1'($urandom), 8'($urandom_range(1, 254)), 23'($urandom)};
        endcase
    endfunction

    logic [31:0] directed[] = '{
        32'h00000000, 32'h80000000, 32'h7FC00000, 32'hFFFFFFFF, 32'h7F800001,
        32'h7F800000, 32'hFF800000, 32'h3F800000, 32'hBF800000, 32'h00000001,
        32'h807FFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00800000, 32'h411FFFFF,
        32'h3DCCCCCD, 32'h42F6E979, 32'h41200000, 32'h447A0000, 32'h3A83126F,
        32'h2EDBE6FF, 32'h5F800000, 32'hC2C80000, 32'h3F7FFFFF
    };

    initial
    begin
        int left;
        int burst;
        board       = new();
        idle_cycles = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_value(directed[i]);
            if ($urandom_range(2) == 0)
                pause_sender();
        end
        pause_sender();

        left = 300;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                send_value(random_value());
                burst--;
                left--;
            end
            pause_sender();
        end
        s_tvalid <= 1'b0;

        while (board.chars_q.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        if (board.errors == 0 && board.chars_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
